[src/tcrt_pkg.sv]
// Shared types, codes and helpers for the texture cache residency tracker.
`default_nettype none

package tcrt_pkg;

    localparam int NUM_UNITS_DEF = 8;

    localparam int CODE_W = 3;
    localparam int OFFSET_W = 15;
    localparam int BASE_W = 20;
    localparam int SIZE_W = 25;
    localparam int TEX_DIM_W = 11;
    localparam int AREA_W = 2 * TEX_DIM_W;
    localparam int NEED_W = AREA_W + 5;
    localparam int MASK_W = 8;
    localparam int IN_TDATA_W = 64;
    localparam int OUT_TDATA_W = 8;

    localparam logic [2:0] OP_SET_EVEN = 3'd0;
    localparam logic [2:0] OP_SET_ODD = 3'd1;
    localparam logic [2:0] OP_OTHER = 3'd2;
    localparam logic [2:0] OP_INV_ALL = 3'd3;
    localparam logic [2:0] OP_BIND = 3'd4;
    localparam logic [2:0] OP_FINALIZE = 3'd5;
    localparam logic [2:0] OP_QUERY = 3'd6;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_VALID = 2'd1;
    localparam logic [1:0] ST_CACHED = 2'd2;

    localparam logic [CODE_W-1:0] CODE_32K = 3'd3;
    localparam logic [CODE_W-1:0] CODE_128K = 3'd4;
    localparam logic [CODE_W-1:0] CODE_512K = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_32K = SIZE_W'(32 * 1024);
    localparam logic [SIZE_W-1:0] SIZE_128K = SIZE_W'(128 * 1024);
    localparam logic [SIZE_W-1:0] SIZE_512K = SIZE_W'(512 * 1024);
    localparam logic [SIZE_W-1:0] SIZE_UNIT = SIZE_W'(512);

    typedef struct packed {
        logic [CODE_W-1:0] width_code;
        logic [CODE_W-1:0] height_code;
        logic [BASE_W-1:0] base;
        logic [SIZE_W-1:0] size;
    } bank_t;

    typedef struct packed {
        bank_t even;
        bank_t odd;
    } entry_t;

    function automatic logic [SIZE_W-1:0] bank_size(input logic [CODE_W-1:0] w,
                                                    input logic [CODE_W-1:0] h);
        logic [CODE_W:0] sh;
        logic [SIZE_W-1:0] sz;
        sh = {1'b0, w} + {1'b0, h};
        sz = SIZE_UNIT << sh;
        if (w == h && w == CODE_32K) begin
            sz = SIZE_32K;
        end else if (w == h && w == CODE_128K) begin
            sz = SIZE_128K;
        end else if (w == h && w == CODE_512K) begin
            sz = SIZE_512K;
        end
        return sz;
    endfunction

    function automatic logic ranges_overlap(input bank_t a, input bank_t b);
        logic [SIZE_W:0] end_a;
        logic [SIZE_W:0] end_b;
        logic hit;
        end_a = (SIZE_W + 1)'(a.base) + (SIZE_W + 1)'(a.size);
        end_b = (SIZE_W + 1)'(b.base) + (SIZE_W + 1)'(b.size);
        hit = (a.base <= b.base && end_a > (SIZE_W + 1)'(b.base)) ||
              (b.base <= a.base && end_b > (SIZE_W + 1)'(a.base));
        return (a.size != '0) && (b.size != '0) && hit;
    endfunction

    function automatic logic units_overlap(input entry_t a, input entry_t b);
        return ranges_overlap(a.even, b.even) || ranges_overlap(a.even, b.odd) ||
               ranges_overlap(a.odd, b.even) || ranges_overlap(a.odd, b.odd);
    endfunction

endpackage

`default_nettype wire

[src/texture_cache_residency_tracker_top.sv]
// Top level of the texture cache residency tracker.
`default_nettype none

// Tracks, per texture unit, two bank settings in a unit table with one write
// port and one registered read port (one entry per unit) and a status of
// invalid, valid or cached. One transaction in gives one transaction out with
// the addressed unit's status after the operation. Query, other-write and
// invalidate-all go from idle straight to the output state; bank writes and
// bind pass through a table read, then modify and write back. Finalize steps
// through the units one table read per cycle. One transaction is in work at
// a time; a finished result waits in the output register while the next
// transaction is accepted.
module texture_cache_residency_tracker_top
    import tcrt_pkg::*;
#(
    parameter int NUM_UNITS = NUM_UNITS_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    // opcode[2:0], unit[5:3], cache_width_code[8:6], cache_height_code[11:9],
    // tmem_offset[26:12], tex_width[37:27], tex_height[48:38], mipmapped[49],
    // wide_texel[50], used_mask[58:51], zero[63:59]
    input  wire [IN_TDATA_W-1:0]    s_axis_tdata,
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    // unit_state[1:0], is_cached[2], is_valid[3], zero[7:4]
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready
);

    localparam int UW = $clog2(NUM_UNITS);
    localparam logic [UW-1:0] LAST_UNIT = UW'(NUM_UNITS - 1);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_RMW       = 6'b000010,
        S_FIN_I     = 6'b000100,
        S_FIN_SELF  = 6'b001000,
        S_FIN_PAIR  = 6'b010000,
        S_OUT       = 6'b100000
    } state_t;

    logic [2:0]           in_op;
    logic [2:0]           in_unit;
    logic [CODE_W-1:0]    in_cw;
    logic [CODE_W-1:0]    in_ch;
    logic [OFFSET_W-1:0]  in_off;
    logic [TEX_DIM_W-1:0] in_tw;
    logic [TEX_DIM_W-1:0] in_th;
    logic                 in_mip;
    logic                 in_wide;
    logic [MASK_W-1:0]    in_mask;
    logic [AREA_W-1:0]    in_area;
    logic [UW-1:0]        in_addr;
    logic                 in_ok;
    logic                 accept;

    state_t               state_reg, state_next;
    logic [2:0]           op_reg;
    logic [UW-1:0]        addr_reg;
    logic                 ok_reg;
    logic [CODE_W-1:0]    cw_reg;
    logic [CODE_W-1:0]    ch_reg;
    logic [OFFSET_W-1:0]  off_reg;
    logic                 mip_reg;
    logic                 wide_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic [NEED_W-1:0]    need_reg;
    logic [NUM_UNITS-1:0] used_vec;

    logic [UW-1:0]        i_reg, i_next;
    logic [UW-1:0]        j_reg, j_next;
    entry_t               ent_i_reg, ent_i_next;

    entry_t               mem [NUM_UNITS];
    entry_t               mem_rd_reg;
    logic                 rd_valid_reg;
    entry_t               rd_ent;
    logic [UW-1:0]        rd_addr;
    logic                 wr_en;
    entry_t               wr_data;
    logic [NUM_UNITS-1:0] vld_reg;

    logic [1:0]           stat_reg [NUM_UNITS];
    logic [1:0]           stat_next [NUM_UNITS];

    logic                 out_load;
    logic [1:0]           out_state;
    logic                 m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign in_op   = s_axis_tdata[2:0];
    assign in_unit = s_axis_tdata[5:3];
    assign in_cw   = s_axis_tdata[8:6];
    assign in_ch   = s_axis_tdata[11:9];
    assign in_off  = s_axis_tdata[26:12];
    assign in_tw   = s_axis_tdata[37:27];
    assign in_th   = s_axis_tdata[48:38];
    assign in_mip  = s_axis_tdata[49];
    assign in_wide = s_axis_tdata[50];
    assign in_mask = s_axis_tdata[58:51];

    assign in_area = AREA_W'(in_tw) * AREA_W'(in_th);
    assign in_addr = UW'(in_unit);
    assign in_ok   = 32'(in_unit) < NUM_UNITS;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign used_vec = NUM_UNITS'(mask_reg);
    assign rd_ent = rd_valid_reg ? mem_rd_reg : '0;

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= in_op;
            addr_reg <= in_addr;
            cw_reg   <= in_cw;
            ch_reg   <= in_ch;
            off_reg  <= in_off;
            mip_reg  <= in_mip;
            wide_reg <= in_wide;
            mask_reg <= in_mask;
            need_reg <= {in_area, 5'b0};
        end
        i_reg     <= i_next;
        j_reg     <= j_next;
        ent_i_reg <= ent_i_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg <= 1'b0;
        end else if (accept) begin
            ok_reg <= in_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr_reg] <= wr_data;
        end
        mem_rd_reg   <= mem[rd_addr];
        rd_valid_reg <= vld_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[addr_reg] <= 1'b1;
        end
    end

    always_comb begin
        logic [SIZE_W-1:0] even_sz;
        logic [SIZE_W-1:0] odd_sz;
        logic              fits;
        entry_t            upd;

        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ent_i_next = ent_i_reg;
        rd_addr    = in_addr;
        wr_en      = 1'b0;
        out_load   = 1'b0;
        for (int k = 0; k < NUM_UNITS; k++) begin
            stat_next[k] = stat_reg[k];
        end

        even_sz = bank_size(rd_ent.even.width_code, rd_ent.even.height_code);
        odd_sz  = '0;
        if (mip_reg || wide_reg) begin
            odd_sz = bank_size(rd_ent.odd.width_code, rd_ent.odd.height_code);
        end
        fits = (need_reg <= NEED_W'(even_sz)) &&
               (!(mip_reg || wide_reg) || need_reg <= NEED_W'(odd_sz));

        upd = rd_ent;
        unique case (op_reg)
            OP_SET_EVEN: begin
                upd.even.width_code  = cw_reg;
                upd.even.height_code = ch_reg;
                upd.even.base        = {off_reg, 5'b0};
                upd.even.size        = '0;
            end
            OP_SET_ODD: begin
                upd.odd.width_code  = cw_reg;
                upd.odd.height_code = ch_reg;
                upd.odd.base        = {off_reg, 5'b0};
                upd.odd.size        = '0;
            end
            OP_BIND: begin
                upd.even.size = mip_reg ? {even_sz[SIZE_W-2:0], 1'b0} : even_sz;
                upd.odd.size  = (mip_reg && wide_reg) ? {odd_sz[SIZE_W-2:0], 1'b0} : odd_sz;
            end
            default: begin
            end
        endcase
        wr_data = upd;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_INV_ALL: begin
                            for (int k = 0; k < NUM_UNITS; k++) begin
                                stat_next[k] = ST_INVALID;
                            end
                            state_next = S_OUT;
                        end
                        OP_FINALIZE: begin
                            i_next     = '0;
                            state_next = S_FIN_I;
                        end
                        OP_OTHER: begin
                            if (in_ok) begin
                                stat_next[in_addr] = ST_INVALID;
                            end
                            state_next = S_OUT;
                        end
                        OP_SET_EVEN, OP_SET_ODD, OP_BIND: begin
                            state_next = in_ok ? S_RMW : S_OUT;
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_RMW: begin
                wr_en = 1'b1;
                if (op_reg == OP_BIND) begin
                    stat_next[addr_reg] = fits ? ST_CACHED : ST_VALID;
                end else begin
                    stat_next[addr_reg] = ST_INVALID;
                end
                state_next = S_OUT;
            end
            S_FIN_I: begin
                rd_addr = i_reg;
                if (used_vec[i_reg]) begin
                    state_next = S_FIN_SELF;
                end else if (i_reg == LAST_UNIT) begin
                    state_next = S_OUT;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_FIN_SELF: begin
                ent_i_next = rd_ent;
                if (ranges_overlap(rd_ent.even, rd_ent.odd)) begin
                    stat_next[i_reg] = ST_VALID;
                end
                rd_addr    = '0;
                j_next     = '0;
                state_next = S_FIN_PAIR;
            end
            S_FIN_PAIR: begin
                if (j_reg != i_reg && stat_reg[i_reg] != ST_INVALID &&
                    stat_reg[j_reg] != ST_INVALID && units_overlap(ent_i_reg, rd_ent)) begin
                    stat_next[i_reg] = ST_VALID;
                    stat_next[j_reg] = ST_VALID;
                end
                rd_addr = j_reg + 1'b1;
                j_next  = j_reg + 1'b1;
                if (j_reg == LAST_UNIT) begin
                    if (i_reg == LAST_UNIT) begin
                        state_next = S_OUT;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_FIN_I;
                    end
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int k = 0; k < NUM_UNITS; k++) begin
                stat_reg[k] <= ST_INVALID;
            end
        end else begin
            state_reg <= state_next;
            for (int k = 0; k < NUM_UNITS; k++) begin
                stat_reg[k] <= stat_next[k];
            end
        end
    end

    assign out_state = ok_reg ? stat_reg[addr_reg] : ST_INVALID;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {4'b0, out_state != ST_INVALID, out_state == ST_CACHED, out_state};
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
